/* rtl/core/box_window_point_suppression_unit_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the box window point suppression unit
// Wrappers that compile to concurrent assertions in simulation and to nothing
// in synthesis.
// ---------------------------------------------------------------------------
`ifndef BOX_WINDOW_POINT_SUPPRESSION_UNIT_MACROS_SVH
`define BOX_WINDOW_POINT_SUPPRESSION_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define BWPS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bwps assertion failed");
`define BWPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bwps assertion failed");
`else
`define BWPS_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define BWPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/bwps_pkg.sv */
// ---------------------------------------------------------------------------
// bwps_pkg
// Shared types of the box window point suppression unit.
// ---------------------------------------------------------------------------
package bwps_pkg;

	localparam int COORD_W = 16;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] s;
	} point_t;

	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctl_t;

endpackage

/* rtl/core/bwps_cell.sv */
// ---------------------------------------------------------------------------
// bwps_cell
// One slot of the point chain: holds a point and its keep flag, compares it
// against the point at the chain head, and shifts toward the head.
// ---------------------------------------------------------------------------
module bwps_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bwps_pkg::cell_ctl_t           ctl,
	input  bwps_pkg::point_t              load_pt,
	input  logic [bwps_pkg::COORD_W-1:0]  thr,
	input  bwps_pkg::point_t              head_pt,
	input  logic                          head_keep,
	input  bwps_pkg::point_t              nb_pt,
	input  logic                          nb_valid,
	input  logic                          nb_keep,
	output bwps_pkg::point_t              pt,
	output logic                          valid,
	output logic                          keep,
	output logic                          keep_next,
	output logic                          drop_head
);

	bwps_pkg::point_t               pt_q;
	logic                           valid_q;
	logic                           keep_q;
	logic [bwps_pkg::COORD_W-1:0]   dx;
	logic [bwps_pkg::COORD_W-1:0]   dy;
	logic                           close;
	logic                           head_wins;
	logic                           active;

	always_comb begin
		dx = (head_pt.x > pt_q.x) ? head_pt.x - pt_q.x : pt_q.x - head_pt.x;
		dy = (head_pt.y > pt_q.y) ? head_pt.y - pt_q.y : pt_q.y - head_pt.y;
		close = (dx < thr) && (dy < thr);
		head_wins = head_pt.s > pt_q.s;
		// a dropped head skips its comparisons entirely
		active = head_keep && valid_q && close;
		keep_next = keep_q && !(active && head_wins);
		drop_head = active && !head_wins;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.load) begin
			valid_q <= 1'b1;
		end else if (ctl.shift) begin
			valid_q <= nb_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			pt_q   <= load_pt;
			keep_q <= 1'b1;
		end else if (ctl.shift) begin
			pt_q   <= nb_pt;
			keep_q <= nb_keep;
		end
	end

	assign pt    = pt_q;
	assign valid = valid_q;
	assign keep  = keep_q;

endmodule

/* rtl/core/box_window_point_suppression_unit.sv */
// ---------------------------------------------------------------------------
// box_window_point_suppression_unit
// Non-maximum suppression of points over a square window, on a chain of cells.
// ---------------------------------------------------------------------------
// Points are loaded one per cycle into a chain of MAX_POINTS cells until the
// request flagged final_point; extra points are dropped and reported on
// capacity_exceeded. Suppression then handles the stored points one at a time:
// the point at the chain head is compared against every later point at once,
// its keep flag becomes final, and the chain shifts one place toward the head.
// Survivors leave in load order, one request behind, so end_of_set can mark the
// last one; once the chain is empty the RUN state hands over to FLUSH, which
// closes the set. Any output stall holds back both suppression and the flush.
// New points are refused from the final point until the last survivor is
// registered at the output.
`include "box_window_point_suppression_unit_macros.svh"

module box_window_point_suppression_unit #(
	parameter int MAX_POINTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] window_half_size,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] pos_x,
	input  logic [15:0] pos_y,
	input  logic [15:0] strength,
	input  logic        final_point,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] kept_x,
	output logic [15:0] kept_y,
	output logic [15:0] kept_strength,
	output logic        end_of_set,
	output logic        capacity_exceeded
);

	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam logic [bwps_pkg::COORD_W-1:0] THR_RESET = bwps_pkg::COORD_W'(48);

	typedef enum logic [2:0] {
		ST_LOAD  = 3'b001,
		ST_RUN   = 3'b010,
		ST_FLUSH = 3'b100
	} st_t;

	st_t                           state_q;
	logic [bwps_pkg::COORD_W-1:0]  thr_q;
	logic [CNT_W-1:0]              count_q;
	logic                          ovf_q;
	bwps_pkg::point_t              pend_q;
	logic                          pend_v_q;
	bwps_pkg::point_t              out_pt_q;
	logic                          out_v_q;
	logic                          out_end_q;
	logic                          out_ovf_q;

	bwps_pkg::point_t              load_pt;
	bwps_pkg::point_t              pts      [MAX_POINTS];
	logic [MAX_POINTS-1:0]         valid_vec;
	logic [MAX_POINTS-1:0]         keep_vec;
	logic [MAX_POINTS-1:0]         keep_nx;
	logic [MAX_POINTS-1:0]         drop_vec;
	bwps_pkg::cell_ctl_t           ctl      [MAX_POINTS];

	logic in_acc;
	logic store_en;
	logic out_free;
	logic step;
	logic head_kept;
	logic flush_go;
	logic out_load;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_LOAD);
	assign in_acc    = in_valid && in_ready;
	assign store_en  = in_acc && (count_q < CNT_W'(MAX_POINTS));
	assign out_free  = !out_v_q || out_ready;
	assign step      = (state_q == ST_RUN) && valid_vec[0] && out_free;
	assign flush_go  = (state_q == ST_FLUSH) && out_free;
	// head survives unless a close later point scores at least as high
	assign head_kept = keep_vec[0] && !(|drop_vec[MAX_POINTS-1:1]);
	assign out_load  = ((step && head_kept) || flush_go) && pend_v_q;

	assign load_pt.x = pos_x;
	assign load_pt.y = pos_y;
	assign load_pt.s = strength;

	for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
		bwps_pkg::point_t nb_pt;
		logic             nb_valid;
		logic             nb_keep;

		if (k == MAX_POINTS - 1) begin : g_tail
			assign nb_pt    = '0;
			assign nb_valid = 1'b0;
			assign nb_keep  = 1'b0;
		end else begin : g_mid
			assign nb_pt    = pts[k+1];
			assign nb_valid = valid_vec[k+1];
			assign nb_keep  = keep_nx[k+1];
		end

		assign ctl[k].load  = store_en && (count_q == CNT_W'(k));
		assign ctl[k].shift = step;

		bwps_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl[k]),
			.load_pt   (load_pt),
			.thr       (thr_q),
			.head_pt   (pts[0]),
			.head_keep (keep_vec[0]),
			.nb_pt     (nb_pt),
			.nb_valid  (nb_valid),
			.nb_keep   (nb_keep),
			.pt        (pts[k]),
			.valid     (valid_vec[k]),
			.keep      (keep_vec[k]),
			.keep_next (keep_nx[k]),
			.drop_head (drop_vec[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= window_half_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			count_q  <= '0;
			ovf_q    <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (store_en) begin
							count_q <= count_q + CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (final_point) begin
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					if (!valid_vec[0]) begin
						state_q <= ST_FLUSH;
					end else if (step && head_kept) begin
						pend_v_q <= 1'b1;
					end
				end
				ST_FLUSH: begin
					if (flush_go) begin
						pend_v_q <= 1'b0;
						count_q  <= '0;
						ovf_q    <= 1'b0;
						state_q  <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// payload side of the survivor path
	always_ff @(posedge clk) begin
		if (step && head_kept) begin
			pend_q <= pts[0];
			if (pend_v_q) begin
				out_pt_q  <= pend_q;
				out_end_q <= 1'b0;
				out_ovf_q <= ovf_q;
			end
		end else if (flush_go && pend_v_q) begin
			out_pt_q  <= pend_q;
			out_end_q <= 1'b1;
			out_ovf_q <= ovf_q;
		end
	end

	assign out_valid         = out_v_q;
	assign kept_x            = out_pt_q.x;
	assign kept_y            = out_pt_q.y;
	assign kept_strength     = out_pt_q.s;
	assign end_of_set        = out_end_q;
	assign capacity_exceeded = out_ovf_q;

	`BWPS_ASSERT_NEXT(a_empty_head_flushes, clk, arst_n,
		(state_q == ST_RUN) && !valid_vec[0], state_q == ST_FLUSH)
	`BWPS_ASSERT_SAME(a_count_matches_cells, clk, arst_n,
		state_q == ST_LOAD, $countones(valid_vec) == int'(count_q))
	`BWPS_ASSERT_NEXT(a_flush_empties_chain, clk, arst_n,
		flush_go, (state_q == ST_LOAD) && !pend_v_q && (count_q == '0))
	`BWPS_ASSERT_SAME(a_overflow_only_when_full, clk, arst_n,
		in_acc && !store_en, count_q == CNT_W'(MAX_POINTS))
	`BWPS_ASSERT_NEXT(a_no_step_while_stalled, clk, arst_n,
		out_v_q && !out_ready && (state_q == ST_RUN) && valid_vec[0],
		$stable(pend_v_q))

endmodule

/* tb/box_window_point_suppression_unit_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// box_window_point_suppression_unit_tb
// Loads point sets through the input channel and checks every survivor that
// leaves the unit against a behavioral copy of the box-window suppression.
// Sets range from single points to sets over capacity, and the window size
// moves through zero, full scale and values in between.
// ---------------------------------------------------------------------------
module box_window_point_suppression_unit_tb;

	localparam int CLK_PERIOD     = 12;
	localparam int RESET_CYCLES   = 9;
	localparam int CAPACITY       = 64;
	localparam int WINDOW_RESET   = 48;
	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_POINTS  = 220;

	typedef struct packed {
		bwps_pkg::point_t pt;
		logic             fin;
	} point_req_t;

	typedef struct packed {
		bwps_pkg::point_t pt;
		logic             last;
		logic             ovf;
	} kept_point_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] window_half_size = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [15:0] pos_x = '0;
	logic [15:0] pos_y = '0;
	logic [15:0] strength = '0;
	logic        final_point = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] kept_x;
	logic [15:0] kept_y;
	logic [15:0] kept_strength;
	logic        end_of_set;
	logic        capacity_exceeded;

	point_req_t  pending_points[$];
	kept_point_t survivors_due[$];

	// behavioral copy of the unit
	bwps_pkg::point_t point_store[CAPACITY];
	int          stored_cnt = 0;
	logic        overflow_flag = 1'b0;
	logic [15:0] window_model = 16'(WINDOW_RESET);

	logic in_fire = 1'b0;
	bit   steady = 1'b0;
	int   send_gap = 0;
	int   hold_left = 0;
	int   quiet_cycles = 0;
	int   cur_thr = WINDOW_RESET;
	int   random_items = 0;
	int   mismatches = 0;
	int   configs_written = 0;
	int   sets_done = 0;
	int   points_seen = 0;
	int   overflow_sets = 0;
	int   survivors_checked = 0;

	box_window_point_suppression_unit #(
		.MAX_POINTS(CAPACITY)
	) i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.window_half_size (window_half_size),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.pos_x            (pos_x),
		.pos_y            (pos_y),
		.strength         (strength),
		.final_point      (final_point),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.kept_x           (kept_x),
		.kept_y           (kept_y),
		.kept_strength    (kept_strength),
		.end_of_set       (end_of_set),
		.capacity_exceeded(capacity_exceeded)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Store one point; on the set's last point run suppression and queue survivors.
	function automatic void absorb_point(point_req_t req);
		bit [CAPACITY-1:0] keep;
		int n, last_idx, dx, dy, thr;
		kept_point_t k;
		if (stored_cnt < CAPACITY) begin
			point_store[stored_cnt] = req.pt;
			stored_cnt++;
		end else begin
			overflow_flag = 1'b1;
		end
		points_seen++;
		if (!req.fin)
			return;
		n = stored_cnt;
		thr = int'(window_model);
		keep = '1;
		for (int i = 0; i < n; i++) begin
			if (!keep[i])
				continue;
			// i goes on comparing even once it has lost a pair
			for (int j = i + 1; j < n; j++) begin
				dx = (point_store[i].x > point_store[j].x) ?
					int'(point_store[i].x - point_store[j].x) :
					int'(point_store[j].x - point_store[i].x);
				dy = (point_store[i].y > point_store[j].y) ?
					int'(point_store[i].y - point_store[j].y) :
					int'(point_store[j].y - point_store[i].y);
				if (dx < thr && dy < thr) begin
					if (point_store[i].s > point_store[j].s)
						keep[j] = 1'b0;
					else
						keep[i] = 1'b0;
				end
			end
		end
		last_idx = n;
		for (int i = 0; i < n; i++)
			if (keep[i])
				last_idx = i;
		for (int i = 0; i < n; i++) begin
			if (keep[i]) begin
				k.pt   = point_store[i];
				k.last = (i == last_idx);
				k.ovf  = overflow_flag;
				survivors_due = {survivors_due, k};
			end
		end
		sets_done++;
		if (overflow_flag)
			overflow_sets++;
		stored_cnt = 0;
		overflow_flag = 1'b0;
	endfunction

	// input driver
	always @(negedge clk) begin
		if (!in_valid || in_fire) begin
			if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_points.size() > 0) begin
				pos_x       <= pending_points[0].pt.x;
				pos_y       <= pending_points[0].pt.y;
				strength    <= pending_points[0].pt.s;
				final_point <= pending_points[0].fin;
				in_valid    <= 1'b1;
				send_gap    <= pick_gap();
				void'(pending_points.pop_front());
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output backpressure
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!steady && $urandom_range(0, 3) == 0) begin
			out_ready <= 1'b0;
			hold_left <= pick_gap();
		end else begin
			out_ready <= 1'b1;
		end
	end

	// monitor and scoreboard
	always @(posedge clk) begin
		kept_point_t want;
		point_req_t  seen;
		in_fire <= in_valid && in_ready;
		if (cfg_valid && cfg_ready) begin
			window_model = window_half_size;
			configs_written++;
		end
		if (out_valid && out_ready) begin
			if (survivors_due.size() == 0) begin
				$error("survivor with no request pending: x %h y %h strength %h",
					kept_x, kept_y, kept_strength);
				mismatches++;
			end else begin
				want = survivors_due.pop_front();
				survivors_checked++;
				if (kept_x !== want.pt.x) begin
					$error("kept_x: expected %h, got %h", want.pt.x, kept_x);
					mismatches++;
				end
				if (kept_y !== want.pt.y) begin
					$error("kept_y: expected %h, got %h", want.pt.y, kept_y);
					mismatches++;
				end
				if (kept_strength !== want.pt.s) begin
					$error("kept_strength: expected %h, got %h", want.pt.s, kept_strength);
					mismatches++;
				end
				if (end_of_set !== want.last) begin
					$error("end_of_set: expected %b, got %b", want.last, end_of_set);
					mismatches++;
				end
				if (capacity_exceeded !== want.ovf) begin
					$error("capacity_exceeded: expected %b, got %b", want.ovf,
						capacity_exceeded);
					mismatches++;
				end
			end
		end
		if (in_valid && in_ready) begin
			seen.pt.x = pos_x;
			seen.pt.y = pos_y;
			seen.pt.s = strength;
			seen.fin  = final_point;
			absorb_point(seen);
		end
	end

	// watchdog on cycles with no request moving anywhere
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic push_point(input int x, input int y, input int s, input bit fin);
		point_req_t req;
		req.pt.x = 16'(x);
		req.pt.y = 16'(y);
		req.pt.s = 16'(s);
		req.fin  = fin;
		pending_points = {pending_points, req};
	endtask

	function automatic int pick_coord(input int base, input int spread);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return $urandom_range(0, 16'hFFFF);
		if (r == 1)
			return $urandom_range(0, 1) ? 16'hFFFF : 0;
		return (base + $urandom_range(0, spread)) & 16'hFFFF;
	endfunction

	// One set clustered around a random spot, spread sized to the window.
	task automatic queue_set(input int n);
		int bx, by, spread, s;
		bit wide_scores;
		bx = $urandom_range(0, 16'hFFFF);
		by = $urandom_range(0, 16'hFFFF);
		spread = cur_thr * 2 + 4;
		if (spread > 16'hFFFF)
			spread = 16'hFFFF;
		wide_scores = ($urandom_range(0, 3) == 0);
		for (int k = 0; k < n; k++) begin
			if (wide_scores)
				s = $urandom_range(0, 16'hFFFF);
			else if ($urandom_range(0, 19) == 0)
				s = 16'hFFFF;
			else
				s = $urandom_range(0, 7);
			push_point(pick_coord(bx, spread), pick_coord(by, spread), s, k == n - 1);
		end
		random_items += n;
	endtask

	// Sender holds off until every survivor is back and the unit has closed the set.
	task automatic drain_and_settle();
		while (pending_points.size() != 0 || in_valid || survivors_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_window(input int value);
		int target;
		target = configs_written + 1;
		@(negedge clk);
		cfg_valid <= 1'b1;
		window_half_size <= 16'(value);
		do @(negedge clk); while (configs_written != target);
		cfg_valid <= 1'b0;
		cur_thr = value;
	endtask

	initial begin
		int thr, n;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset window of 48
		push_point(0, 0, 0, 1);                    // lone point
		push_point(16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
		push_point(16'hFFFF, 16'hFFFF, 16'hFFFF, 1); // tie drops the earlier point
		push_point(100, 100, 500, 0);
		push_point(130, 100, 400, 0);              // loses to the first
		push_point(160, 100, 300, 1);              // outside the first's window
		push_point(100, 100, 200, 0);              // dropped by next, still kills the last
		push_point(70, 100, 300, 0);
		push_point(140, 100, 100, 1);
		push_point(1000, 1000, 5, 0);
		push_point(1048, 1000, 9, 0);              // distance equal to window: not close
		push_point(1000, 1047, 3, 1);
		push_point(20000, 30000, 16'hFFFF, 0);
		push_point(20001, 30001, 0, 1);
		drain_and_settle();

		write_window(0);                           // nothing is ever close
		push_point(5, 5, 1, 0);
		push_point(5, 5, 1, 1);
		drain_and_settle();

		write_window(16'hFFFF);
		push_point(0, 0, 3, 0);
		push_point(16'hFFFF, 16'hFFFF, 7, 0);
		push_point(0, 16'hFFFF, 7, 0);
		push_point(100, 200, 2, 1);
		drain_and_settle();

		for (int phase = 0; random_items < RANDOM_POINTS; phase++) begin
			steady = (phase % 4 == 3);
			case (phase % 8)
				0: thr = 1;
				1: thr = 16;
				2: thr = WINDOW_RESET;
				3: thr = $urandom_range(2, 400);
				4: thr = 0;
				5: thr = 16'hFFFF;
				6: thr = 4096;
				default: thr = $urandom_range(0, 16'hFFFF);
			endcase
			write_window(thr);
			if (phase == 2) begin
				queue_set(CAPACITY + 2);           // overflow on the last two points
			end else if (phase == 6) begin
				queue_set(CAPACITY);               // exactly full
			end else begin
				repeat ($urandom_range(1, 4)) begin
					n = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
					queue_set(n);
				end
			end
			drain_and_settle();
		end
		steady = 1'b0;

		$display("Ran %0d sets with %0d points; %0d survivors checked, %0d sets over capacity.",
			sets_done, points_seen, survivors_checked, overflow_sets);
		$display("Window size written %0d times, including zero and full scale.",
			configs_written);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/bwps_pkg.sv
rtl/core/bwps_cell.sv
rtl/core/box_window_point_suppression_unit.sv
tb/box_window_point_suppression_unit_tb.sv
